@@ hw/rtl/htn_pkg.sv @@
// Shared types, character codes and the byte classifier of the HTML text normalizer.
// Used by htn_front, htn_back and html_text_normalizer.
package htn_pkg;

  localparam int unsigned ENTITY_SPAN_DEF = 9;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_LBRK     = 8'h5B;
  localparam logic [7:0] CH_RBRK     = 8'h5D;
  localparam logic [7:0] CH_LPAR     = 8'h28;
  localparam logic [7:0] CH_RPAR     = 8'h29;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [3:0] {
    CLS_CTRL,
    CLS_SPACE,
    CLS_LT,
    CLS_GT,
    CLS_AMP,
    CLS_SEMI,
    CLS_UPPER,
    CLS_QUOTE,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_HIGH
  } cls_e;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_TAG,
    MODE_ENTITY
  } mode_e;

  typedef enum logic [1:0] {
    BK_FEED,
    BK_EMIT,
    BK_DONE
  } bk_st_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_e       cls;
  } q_item_t;

  function automatic cls_e classify(input logic [7:0] b);
    cls_e c;
    if (b < CH_SPACE) c = CLS_CTRL;
    else if (b == CH_SPACE) c = CLS_SPACE;
    else if (b == CH_LT) c = CLS_LT;
    else if (b == CH_GT) c = CLS_GT;
    else if (b == CH_AMP) c = CLS_AMP;
    else if (b == CH_SEMI) c = CLS_SEMI;
    else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) c = CLS_UPPER;
    else if (b == CH_DQUOTE || b == CH_SQUOTE) c = CLS_QUOTE;
    else if (b < 8'h80) c = CLS_ASCII;
    else if (b >= 8'hC0 && b <= 8'hDF) c = CLS_LEAD2;
    else if (b >= 8'hE0 && b <= 8'hEF) c = CLS_LEAD3;
    else if (b >= 8'hF0 && b <= 8'hF7) c = CLS_LEAD4;
    else c = CLS_HIGH;
    return c;
  endfunction

endpackage

@@ hw/rtl/htn_front.sv @@
// Front end of the normalizer: accepts input words, classifies each byte and
// holds them in a two-entry queue for the back end. Depends on htn_pkg.
module htn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             q_valid_o,
  output htn_pkg::q_item_t q_item_o,
  input  logic             q_pop_i
);
  import htn_pkg::*;

  q_item_t    mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    push  = in_valid_i && !in_stall_o;
    pop   = q_pop_i && q_valid_o;
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: in_byte_i, last: in_last_i, cls: classify(in_byte_i)};
    end
  end

endmodule

@@ hw/rtl/htn_back.sv @@
// Back end of the normalizer: scanning state machine, entity lookahead and replay,
// UTF-8 gathering and the output register. Depends on htn_pkg.
module htn_back #(
  parameter int unsigned SPAN = htn_pkg::ENTITY_SPAN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  htn_pkg::q_item_t q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             has_byte_o,
  output logic             out_last_o
);
  import htn_pkg::*;

  localparam int unsigned IW = $clog2(SPAN);
  localparam int unsigned CW = $clog2(SPAN + 1);
  localparam logic [20:0] CP_IDEO_SPACE = 21'd12288;

  function automatic logic [8:0] map_cp(input logic [20:0] cp);
    logic [8:0] r;
    unique case (cp)
      21'd12289, 21'd65292, 21'd65306, 21'd65307, 21'd65374: r = {1'b1, CH_COMMA};
      21'd12290: r = {1'b1, CH_DOT};
      21'd65281: r = {1'b1, CH_BANG};
      21'd65311: r = {1'b1, CH_QMARK};
      21'd12304: r = {1'b1, CH_LBRK};
      21'd12305: r = {1'b1, CH_RBRK};
      21'd65288: r = {1'b1, CH_LPAR};
      21'd65289: r = {1'b1, CH_RPAR};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  bk_st_e        st_q, st_d;
  mode_e         mode_q, mode_d;
  logic [7:0]    la_q [SPAN];
  logic [7:0]    la_d [SPAN];
  logic [7:0]    rp_q [SPAN];
  logic [7:0]    rp_d [SPAN];
  logic [CW-1:0] la_cnt_q, la_cnt_d, rp_n_q, rp_n_d, rp_idx_q, rp_idx_d;
  logic [31:0]   gat_q, gat_d, em_q, em_d;
  logic [2:0]    rem_q, rem_d, tot_q, tot_d, em_n_q, em_n_d;
  logic          lws_q, lws_d, fed_q, fed_d;
  logic          hold_v_q, hold_v_d;
  logic [7:0]    hold_q, hold_d;
  logic          out_v_q, out_v_d, out_has_q, out_has_d, out_last_q, out_last_d;
  logic [7:0]    out_byte_q, out_byte_d;

  logic          slot_free, feed_go, abort_go, done_go, emit_go;
  logic [31:0]   el;
  logic [2:0]    en;

  assign slot_free   = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_byte_o  = out_byte_q;
  assign has_byte_o  = out_has_q;
  assign out_last_o  = out_last_q;

  always_comb begin : datapath
    logic [31:0] g;
    logic [20:0] cp;
    logic [8:0]  mp;
    logic [7:0]  fb;
    logic [7:0]  lastb;
    cls_e        fc;
    mode_d     = mode_q;
    la_d       = la_q;
    rp_d       = rp_q;
    la_cnt_d   = la_cnt_q;
    rp_n_d     = rp_n_q;
    rp_idx_d   = rp_idx_q;
    gat_d      = gat_q;
    rem_d      = rem_q;
    tot_d      = tot_q;
    lws_d      = lws_q;
    fed_d      = fed_q;
    em_d       = em_q;
    em_n_d     = em_n_q;
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    out_v_d    = out_v_q && out_stall_i;
    out_has_d  = out_has_q;
    out_last_d = out_last_q;
    out_byte_d = out_byte_q;
    q_pop_o    = 1'b0;
    feed_go    = 1'b0;
    abort_go   = 1'b0;
    done_go    = 1'b0;
    emit_go    = 1'b0;
    el         = 32'd0;
    en         = 3'd0;
    g          = 32'd0;
    cp         = 21'd0;
    mp         = 9'd0;
    lastb      = 8'd0;
    fb         = rp_q[rp_idx_q[IW-1:0]];
    fc         = classify(fb);

    if (st_q == BK_FEED) begin
      if (rp_idx_q < rp_n_q) begin
        feed_go  = 1'b1;
        rp_idx_d = rp_idx_q + 1'b1;
      end else if (q_valid_i && !fed_q) begin
        feed_go = 1'b1;
        fed_d   = 1'b1;
        fb      = q_item_i.data;
        fc      = q_item_i.cls;
      end else if (q_valid_i && q_item_i.last && mode_q == MODE_ENTITY) begin
        // End of document with an open entity: abort it and replay what it held.
        abort_go = 1'b1;
        rp_d     = la_q;
        rp_n_d   = la_cnt_q;
        rp_idx_d = '0;
        mode_d   = MODE_TEXT;
        la_cnt_d = '0;
        el       = {CH_AMP, 24'd0};
        en       = 3'd1;
      end else if (q_valid_i) begin
        done_go = 1'b1;
        if (q_item_i.last) begin
          mode_d   = MODE_TEXT;
          la_cnt_d = '0;
          gat_d    = 32'd0;
          rem_d    = 3'd0;
          tot_d    = 3'd0;
          lws_d    = 1'b0;
        end
      end
    end

    if (feed_go) begin
      unique case (mode_q)
        MODE_TAG: begin
          if (fc == CLS_GT) mode_d = MODE_TEXT;
        end
        MODE_ENTITY: begin
          if (fc == CLS_SEMI) begin
            mode_d   = MODE_TEXT;
            la_cnt_d = '0;
          end else begin
            la_d[la_cnt_q[IW-1:0]] = fb;
            if (la_cnt_q == CW'(SPAN - 1)) begin
              // No semicolon within the span: write '&' and replay the buffer.
              for (int i = 0; i < SPAN; i++) rp_d[i] = la_d[i];
              rp_n_d   = CW'(SPAN);
              rp_idx_d = '0;
              mode_d   = MODE_TEXT;
              la_cnt_d = '0;
              el       = {CH_AMP, 24'd0};
              en       = 3'd1;
            end else begin
              la_cnt_d = la_cnt_q + 1'b1;
            end
          end
        end
        default: begin
          if (rem_q != 3'd0) begin
            g     = {gat_q[23:0], fb};
            rem_d = rem_q - 3'd1;
            if (rem_q == 3'd1) begin
              unique case (tot_q)
                3'd2:    cp = {10'd0, g[12:8], g[5:0]};
                3'd3:    cp = {5'd0, g[19:16], g[13:8], g[5:0]};
                default: cp = {g[26:24], g[21:16], g[13:8], g[5:0]};
              endcase
              mp = map_cp(cp);
              if (mp[8]) begin
                el = {mp[7:0], 24'd0};
                en = 3'd1;
              end else if (cp == CP_IDEO_SPACE) begin
                if (!lws_q) begin
                  el = {CH_SPACE, 24'd0};
                  en = 3'd1;
                end
              end else begin
                unique case (tot_q)
                  3'd2: begin
                    el = {g[15:0], 16'd0};
                    en = 3'd2;
                  end
                  3'd3: begin
                    el = {g[23:0], 8'd0};
                    en = 3'd3;
                  end
                  default: begin
                    el = g;
                    en = 3'd4;
                  end
                endcase
              end
              gat_d = 32'd0;
              tot_d = 3'd0;
            end else begin
              gat_d = g;
            end
          end else begin
            unique case (fc)
              CLS_CTRL: ;
              CLS_SPACE: begin
                if (!lws_q) begin
                  el = {CH_SPACE, 24'd0};
                  en = 3'd1;
                end
              end
              CLS_LT: mode_d = MODE_TAG;
              CLS_AMP: begin
                mode_d   = MODE_ENTITY;
                la_cnt_d = '0;
              end
              CLS_UPPER: begin
                el = {fb + CASE_OFFSET, 24'd0};
                en = 3'd1;
              end
              CLS_QUOTE: begin
                el = {CH_BSLASH, fb, 16'd0};
                en = 3'd2;
              end
              CLS_LEAD2: begin
                gat_d = {24'd0, fb};
                tot_d = 3'd2;
                rem_d = 3'd1;
              end
              CLS_LEAD3: begin
                gat_d = {24'd0, fb};
                tot_d = 3'd3;
                rem_d = 3'd2;
              end
              CLS_LEAD4: begin
                gat_d = {24'd0, fb};
                tot_d = 3'd4;
                rem_d = 3'd3;
              end
              default: begin
                el = {fb, 24'd0};
                en = 3'd1;
              end
            endcase
          end
        end
      endcase
    end

    if (en != 3'd0) begin
      unique case (en)
        3'd1:    lastb = el[31:24];
        3'd2:    lastb = el[23:16];
        3'd3:    lastb = el[15:8];
        default: lastb = el[7:0];
      endcase
      em_d   = el;
      em_n_d = en;
      lws_d  = (lastb == CH_SPACE);
    end

    // The newest byte waits in the hold register so that the last one of a
    // document can be flagged once the word is fully processed.
    if (st_q == BK_EMIT && (!hold_v_q || slot_free)) begin
      emit_go = 1'b1;
      if (hold_v_q) begin
        out_v_d    = 1'b1;
        out_byte_d = hold_q;
        out_has_d  = 1'b1;
        out_last_d = 1'b0;
      end
      hold_d   = em_q[31:24];
      hold_v_d = 1'b1;
      em_d     = {em_q[23:0], 8'd0};
      em_n_d   = em_n_q - 3'd1;
    end

    if (st_q == BK_DONE && slot_free) begin
      q_pop_o  = 1'b1;
      fed_d    = 1'b0;
      hold_v_d = 1'b0;
      if (q_item_i.last || hold_v_q) begin
        out_v_d    = 1'b1;
        out_byte_d = hold_v_q ? hold_q : 8'd0;
        out_has_d  = hold_v_q;
        out_last_d = q_item_i.last;
      end
    end
  end

  always_comb begin : next_state
    st_d = st_q;
    unique case (st_q)
      BK_FEED: begin
        if (abort_go || (feed_go && en != 3'd0)) st_d = BK_EMIT;
        else if (done_go) st_d = BK_DONE;
      end
      BK_EMIT: begin
        if (emit_go && em_n_q == 3'd1) st_d = BK_FEED;
      end
      BK_DONE: begin
        if (slot_free) st_d = BK_FEED;
      end
      default: st_d = BK_FEED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= BK_FEED;
      mode_q   <= MODE_TEXT;
      la_cnt_q <= '0;
      rp_n_q   <= '0;
      rp_idx_q <= '0;
      gat_q    <= 32'd0;
      rem_q    <= 3'd0;
      tot_q    <= 3'd0;
      lws_q    <= 1'b0;
      fed_q    <= 1'b0;
      em_n_q   <= 3'd0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      mode_q   <= mode_d;
      la_cnt_q <= la_cnt_d;
      rp_n_q   <= rp_n_d;
      rp_idx_q <= rp_idx_d;
      gat_q    <= gat_d;
      rem_q    <= rem_d;
      tot_q    <= tot_d;
      lws_q    <= lws_d;
      fed_q    <= fed_d;
      em_n_q   <= em_n_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la_q       <= la_d;
    rp_q       <= rp_d;
    em_q       <= em_d;
    hold_q     <= hold_d;
    out_byte_q <= out_byte_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  a_la_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    la_cnt_q < CW'(SPAN)) else $error("lookahead count reached the entity span");

  a_utf8_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 3'd0) |-> (mode_q == MODE_TEXT)) else $error("UTF-8 gather outside text");

  a_feed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BK_FEED) |-> (em_n_q == 3'd0)) else $error("feeding with bytes pending");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_has_q) |-> (out_last_q && out_byte_q == 8'd0))
    else $error("empty result that is not the document end");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (q_valid_i && fed_q)) else $error("queue popped before the word was fed");

endmodule

@@ hw/rtl/html_text_normalizer.sv @@
// HTML text normalizer top level: the front queue and the back-end engine.
// Depends on htn_pkg, htn_front and htn_back.
//
// Usage: the input channel (in_valid_i / in_stall_o) takes one document byte per
// word, with in_last_i set on the final byte. The output channel (out_valid_o /
// out_stall_i) gives normalized bytes; has_byte_o is low only on the empty word
// that closes a document whose final byte produced nothing, and out_last_o marks the final
// word of each document.
// Operation: the engine scans a byte, writes each byte that it produces and
// then closes the word; a dropped byte is only scanned and closed. An aborted
// entity first writes its '&' (after an extra abort step when the end of the
// document aborts it), then scans each replayed byte (up to ENTITY_SPAN) and
// writes their bytes. A byte's output appears once the next written byte or
// the end of its word pushes it out of the hold stage.
// The two-entry front queue keeps accepting while the engine works, until both entries are full.
// Reset clears the queue, the scan state and the output register; the first
// byte may be presented in the cycle after reset is released.
// A stalled output holds its word; the engine then waits and the queue fills,
// after which in_stall_o rises.
module html_text_normalizer #(
  parameter int unsigned ENTITY_SPAN = htn_pkg::ENTITY_SPAN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       out_last_o
);
  import htn_pkg::*;

  logic    q_valid, q_pop;
  q_item_t q_item;

  htn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  htn_back #(
    .SPAN (ENTITY_SPAN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule
